[design/bchd_pkg.sv]
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResAw      = $clog2(MaxResults);
  localparam int unsigned NumSlots   = 4;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);
  localparam int unsigned FifoCw     = $clog2(FifoDepth + 1);
  localparam int unsigned PushCw     = $clog2(MaxResults + 1);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic signed [8:0] HoldValue  = -9'sd1;
  localparam logic signed [8:0] ResetValue = 9'sd0;

  typedef enum logic [1:0] {
    EvClicks     = 2'd0,
    EvHoldStart  = 2'd1,
    EvHoldEnd    = 2'd2,
    EvStateReset = 2'd3
  } ev_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce    = 3'd0,
    CfgClickWindow = 3'd1,
    CfgHoldDelay   = 3'd2,
    CfgMaxClicks   = 3'd3,
    CfgResetDelay  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] click_window_ms;
    logic [15:0] hold_delay_ms;
    logic [7:0]  max_clicks;
    logic [15:0] state_reset_delay_ms;
  } cfg_t;

  typedef struct packed {
    ev_kind_e          kind;
    logic signed [8:0] value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [PushCw-1:0]                cnt;
    result_t [MaxResults-1:0]         data;
  } push_t;

endpackage

[design/bchd_in_if.sv]
`timescale 1ns / 1ps

interface bchd_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

[design/bchd_out_if.sv]
`timescale 1ns / 1ps

interface bchd_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic signed [8:0] reported_value;
  logic              last_of_run;

  modport source (output valid, output event_kind, output reported_value,
                  output last_of_run, input ready);
  modport sink (input valid, input event_kind, input reported_value,
                input last_of_run, output ready);
endinterface

[design/button_click_hold_detector.sv]
// A transferred sample waits in the sample register and is evaluated once
// the result queue has room; its results are written to the queue.
// Throughput: one sample per cycle while the 4-entry result queue has room
// for three results; results leave one per cycle while ready is high.
// Reset: asynchronous, active low; control registers return to defaults.
`timescale 1ns / 1ps

module button_click_hold_detector import bchd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  bchd_in_if.sink             in_i,
  bchd_out_if.source          out_o
);

  cfg_t  cfg;
  push_t push;
  logic  space;

  bchd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push)
  );

  bchd_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

[design/bchd_cfg.sv]
`timescale 1ns / 1ps

module bchd_cfg import bchd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms          <= 16'd50;
      cfg_q.click_window_ms      <= 16'd500;
      cfg_q.hold_delay_ms        <= 16'd1000;
      cfg_q.max_clicks           <= 8'd3;
      cfg_q.state_reset_delay_ms <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDebounce:    cfg_q.debounce_ms          <= cfg_wdata_i;
        CfgClickWindow: cfg_q.click_window_ms      <= cfg_wdata_i;
        CfgHoldDelay:   cfg_q.hold_delay_ms        <= cfg_wdata_i;
        CfgMaxClicks:   cfg_q.max_clicks           <= cfg_wdata_i[7:0];
        CfgResetDelay:  cfg_q.state_reset_delay_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/bchd_core.sv]
`timescale 1ns / 1ps

module bchd_core import bchd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  bchd_in_if.sink   in_i,
  input  logic      space_i,
  output push_t     push_o
);

  // sample register
  logic        s_valid_q;
  logic        s_level_q;
  logic [31:0] s_now_q;
  logic        consume;

  // detector state
  logic        prev_raw_q, prev_raw_d;
  logic        deb_q, deb_d;
  logic        prev_pressed_q, prev_pressed_d;
  logic        holding_q, holding_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] lct_q, lct_d;
  logic [31:0] press_q, press_d;
  logic [31:0] click_q, click_d;
  logic [31:0] rts_q, rts_d;
  logic        rep_pos_q, rep_pos_d;

  logic [7:0]  pend_mid, pend_inc;
  logic [31:0] tstart;
  logic        a_fire, b_fire, c_fire, d_fire;
  logic        max_hit, win_hit, hold_hit;
  ev_kind_e    b_kind;
  logic [7:0]  a_val;

  result_t [NumSlots-1:0]   slot;
  logic    [NumSlots-1:0]   slot_v;
  result_t [MaxResults-1:0] res;
  logic    [PushCw-1:0]     idx;

  assign consume    = s_valid_q && space_i;
  assign in_i.ready = !s_valid_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s_level_q <= in_i.pin_level;
      s_now_q   <= in_i.now_ms;
    end
  end

  always_comb begin
    lct_d          = (s_level_q != prev_raw_q) ? s_now_q : lct_q;
    deb_d          = ((s_now_q - lct_d) > {16'd0, cfg_i.debounce_ms}) ? s_level_q : deb_q;
    press_d        = press_q;
    holding_d      = holding_q;
    click_d        = click_q;
    pend_mid       = pend_q;
    pend_inc       = (pend_q == 8'hFF) ? pend_q : pend_q + 8'd1;
    hold_hit       = (s_now_q - press_q) >= {16'd0, cfg_i.hold_delay_ms};
    a_fire         = 1'b0;
    a_val          = pend_q;
    b_fire         = 1'b0;
    b_kind         = EvHoldStart;
    max_hit        = 1'b0;

    if (deb_d) begin
      if (!prev_pressed_q) begin
        press_d = s_now_q;
      end else if (!holding_q && hold_hit) begin
        a_fire    = pend_q != 8'd0;
        pend_mid  = 8'd0;
        holding_d = 1'b1;
        b_fire    = 1'b1;
        b_kind    = EvHoldStart;
      end
    end else begin
      if (holding_q) begin
        holding_d = 1'b0;
        b_fire    = 1'b1;
        b_kind    = EvHoldEnd;
      end else if (prev_pressed_q) begin
        pend_mid = pend_inc;
        click_d  = s_now_q;
        max_hit  = pend_inc >= cfg_i.max_clicks;
      end
    end

    win_hit        = (s_now_q - click_d) >= {16'd0, cfg_i.click_window_ms};
    c_fire         = (pend_mid != 8'd0) && (max_hit || win_hit);
    pend_d         = c_fire ? 8'd0 : pend_mid;
    prev_raw_d     = s_level_q;
    prev_pressed_d = deb_d;

    // sign of the last published value
    if (c_fire) begin
      rep_pos_d = 1'b1;
    end else if (b_fire) begin
      rep_pos_d = 1'b0;
    end else begin
      rep_pos_d = rep_pos_q;
    end

    tstart = (rts_q == 32'd0) ? s_now_q : rts_q;
    d_fire = 1'b0;
    rts_d  = rts_q;
    if (rep_pos_d) begin
      d_fire = (s_now_q - tstart) > {16'd0, cfg_i.state_reset_delay_ms};
      rts_d  = d_fire ? 32'd0 : tstart;
      if (d_fire) begin
        rep_pos_d = 1'b0;
      end
    end
  end

  // results in order: pending count, hold event, click count, state reset
  always_comb begin
    slot[0] = '{kind: EvClicks, value: $signed({1'b0, a_val}), last: 1'b0};
    slot[1] = '{kind: b_kind, value: HoldValue, last: 1'b0};
    slot[2] = '{kind: EvClicks, value: $signed({1'b0, pend_mid}), last: 1'b0};
    slot[3] = '{kind: EvStateReset, value: ResetValue, last: 1'b0};
    slot_v  = {d_fire, c_fire, b_fire, a_fire};
    res     = '0;
    idx     = '0;
    for (int k = 0; k < NumSlots; k++) begin
      if (slot_v[k] && (idx < PushCw'(MaxResults))) begin
        res[idx[ResAw-1:0]] = slot[k];
        idx = idx + PushCw'(1);
      end
    end
    for (int j = 0; j < MaxResults; j++) begin
      res[j].last = (PushCw'(j + 1) == idx);
    end
    push_o.data = res;
    push_o.cnt  = consume ? idx : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q     <= 1'b0;
      deb_q          <= 1'b0;
      prev_pressed_q <= 1'b0;
      holding_q      <= 1'b0;
      pend_q         <= 8'd0;
      lct_q          <= 32'd0;
      press_q        <= 32'd0;
      click_q        <= 32'd0;
      rts_q          <= 32'd0;
      rep_pos_q      <= 1'b0;
    end else if (consume) begin
      prev_raw_q     <= prev_raw_d;
      deb_q          <= deb_d;
      prev_pressed_q <= prev_pressed_d;
      holding_q      <= holding_d;
      pend_q         <= pend_d;
      lct_q          <= lct_d;
      press_q        <= press_d;
      click_q        <= click_d;
      rts_q          <= rts_d;
      rep_pos_q      <= rep_pos_d;
    end
  end

endmodule

[design/bchd_res_fifo.sv]
`timescale 1ns / 1ps

module bchd_res_fifo import bchd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       space_o,
  bchd_out_if.source out_o
);

  result_t            mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoCw-1:0]  count_q;
  logic               pop;
  result_t            head;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = count_q <= FifoCw'(FifoDepth - MaxResults);
  assign head    = mem_q[rd_ptr_q];

  assign out_o.valid          = count_q != '0;
  assign out_o.event_kind     = head.kind;
  assign out_o.reported_value = head.value;
  assign out_o.last_of_run    = head.last;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MaxResults; j++) begin
      if (PushCw'(j) < push_i.cnt) begin
        mem_q[wr_ptr_q + FifoAw'(j)] <= push_i.data[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoAw'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      count_q <= count_q + FifoCw'(push_i.cnt) - FifoCw'(pop);
    end
  end

endmodule
